[hdl/mono_framebuffer_raster_engine_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the raster engine checker
// Clocked, reset-qualified property shorthands used by the bound checker.
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_RASTER_ENGINE_TOP_DEFINES_SVH
`define MONO_FRAMEBUFFER_RASTER_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define MFRE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MFRE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mfre_pkg.sv]
// ----------------------------------------------------------------------------
// mfre_pkg
// Shared types and constants of the monochrome framebuffer raster engine.
// ----------------------------------------------------------------------------
package mfre_pkg;

    // default screen geometry
    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;

    // fixed field widths
    localparam int CMD_W   = 3;
    localparam int COORD_W = 9;   // signed request coordinates
    localparam int PIX_W   = 8;   // clipped on-screen coordinate
    localparam int IDX_W   = 10;  // byte index of the read request
    localparam int DATA_W  = 8;

    // request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_SET_PX   = 3'd0,
        CMD_CLR_PX   = 3'd1,
        CMD_INV_PX   = 3'd2,
        CMD_FILL_BOX = 3'd3,
        CMD_CLR_BOX  = 3'd4,
        CMD_INV_BOX  = 3'd5,
        CMD_CLR_ALL  = 3'd6,
        CMD_READ     = 3'd7
    } t_cmd;

    // pixel operation applied by the walk
    typedef enum logic [1:0] {
        OP_SET = 2'd0,
        OP_CLR = 2'd1,
        OP_INV = 2'd2
    } t_op;

    // finished result handed from the sequencer to the output stage
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] read_data;
        logic              touched;
    } t_res;

endpackage

[hdl/mfre_store.sv]
// ----------------------------------------------------------------------------
// mfre_store
// Framebuffer byte memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mfre_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/mfre_seq.sv]
// ----------------------------------------------------------------------------
// mfre_seq
// Request sequencer: clipping, byte walk with read-modify-write, clear sweep, byte read.
// ----------------------------------------------------------------------------
module mfre_seq #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int BUFSIZE       = 1024,
    parameter int AW            = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request side
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_cmd,
    input  logic signed [8:0]     i_x_start,
    input  logic signed [8:0]     i_y_start,
    input  logic signed [8:0]     i_x_end,
    input  logic signed [8:0]     i_y_end,
    input  logic [9:0]            i_byte_index,
    // result side
    output mfre_pkg::t_res        o_res,
    input  logic                  i_res_take,
    // memory
    output logic                  o_rd_en,
    output logic [AW-1:0]         o_rd_addr,
    input  logic [7:0]            i_rd_data,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output logic [7:0]            o_wr_data
);
    import mfre_pkg::*;

    localparam int EW = ((AW + 1) > IDX_W) ? (AW + 1) : IDX_W;
    localparam logic signed [COORD_W:0] XMAX = (COORD_W+1)'(SCREEN_WIDTH - 1);
    localparam logic signed [COORD_W:0] YMAX = (COORD_W+1)'(SCREEN_HEIGHT - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_CLIP  = 8'b0000_0100,
        S_BASE  = 8'b0000_1000,
        S_WALK  = 8'b0001_0000,
        S_FLUSH = 8'b0010_0000,
        S_READ  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state                     r_state, n_state;
    t_op                        r_op, n_op;
    logic signed [COORD_W-1:0]  r_xs, n_xs, r_ys, n_ys, r_xe, n_xe, r_ye, n_ye;
    logic [PIX_W-1:0]           r_x1, n_x1, r_x2, n_x2, r_y1, n_y1, r_y2, n_y2;
    logic [PIX_W-1:0]           r_x, n_x;
    logic [PIX_W-4:0]           r_bank, n_bank;
    logic [AW-1:0]              r_idx, n_idx, r_row_idx, n_row_idx;
    logic [AW-1:0]              r_cnt, n_cnt;
    logic                       r_clr_cmd, n_clr_cmd;
    logic                       r_wb_valid, n_wb_valid;
    logic [AW-1:0]              r_wb_addr, n_wb_addr;
    logic [7:0]                 r_wb_mask, n_wb_mask;
    logic [7:0]                 r_res_data, n_res_data;
    logic                       r_res_touched, n_res_touched;

    logic                       w_accept;
    logic [EW-1:0]              w_bidx_ext;
    logic                       w_bidx_ok;
    logic signed [COORD_W:0]    w_xs, w_ys, w_xe, w_ye, w_x1, w_y1, w_x2, w_y2;
    logic [2:0]                 w_lo, w_hi;
    logic [7:0]                 w_mask;
    logic [AW-1:0]              w_bank_off;
    logic [7:0]                 w_new_byte;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // read request range check
    assign w_bidx_ext = EW'(i_byte_index);
    assign w_bidx_ok  = (w_bidx_ext < EW'(BUFSIZE));

    // clip the box to the screen
    assign w_xs = {r_xs[COORD_W-1], r_xs};
    assign w_ys = {r_ys[COORD_W-1], r_ys};
    assign w_xe = {r_xe[COORD_W-1], r_xe};
    assign w_ye = {r_ye[COORD_W-1], r_ye};
    assign w_x1 = (w_xs < 0) ? '0 : w_xs;
    assign w_y1 = (w_ys < 0) ? '0 : w_ys;
    assign w_x2 = (w_xe > XMAX) ? XMAX : w_xe;
    assign w_y2 = (w_ye > YMAX) ? YMAX : w_ye;

    // byte offset of the top bank row
    assign w_bank_off = AW'(r_y1[PIX_W-1:3]) * AW'(SCREEN_WIDTH);

    // row mask of the current bank, bit 7 is the top row
    assign w_lo   = (r_bank == r_y1[PIX_W-1:3]) ? r_y1[2:0] : 3'd0;
    assign w_hi   = (r_bank == r_y2[PIX_W-1:3]) ? r_y2[2:0] : 3'd7;
    assign w_mask = (8'hFF >> w_lo) & (8'hFF << (3'd7 - w_hi));

    // modify stage of the read-modify-write
    always_comb begin
        unique case (r_op)
            OP_SET:  w_new_byte = i_rd_data | r_wb_mask;
            OP_CLR:  w_new_byte = i_rd_data & ~r_wb_mask;
            OP_INV:  w_new_byte = i_rd_data ^ r_wb_mask;
            default: w_new_byte = i_rd_data;
        endcase
    end

    // memory ports
    assign o_rd_en   = (r_state == S_WALK) ||
                       (w_accept && (t_cmd'(i_cmd) == CMD_READ) && w_bidx_ok);
    assign o_rd_addr = (r_state == S_WALK) ? r_idx : w_bidx_ext[AW-1:0];
    assign o_wr_en   = (r_state == S_CLEAR) || r_wb_valid;
    assign o_wr_addr = (r_state == S_CLEAR) ? r_cnt : r_wb_addr;
    assign o_wr_data = (r_state == S_CLEAR) ? 8'h00 : w_new_byte;

    // result
    assign o_res.valid     = (r_state == S_DONE);
    assign o_res.read_data = r_res_data;
    assign o_res.touched   = r_res_touched;

    // next state
    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_xs          = r_xs;
        n_ys          = r_ys;
        n_xe          = r_xe;
        n_ye          = r_ye;
        n_x1          = r_x1;
        n_x2          = r_x2;
        n_y1          = r_y1;
        n_y2          = r_y2;
        n_x           = r_x;
        n_bank        = r_bank;
        n_idx         = r_idx;
        n_row_idx     = r_row_idx;
        n_cnt         = r_cnt;
        n_clr_cmd     = r_clr_cmd;
        n_wb_valid    = 1'b0;
        n_wb_addr     = r_wb_addr;
        n_wb_mask     = r_wb_mask;
        n_res_data    = r_res_data;
        n_res_touched = r_res_touched;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_xs = i_x_start;
                    n_ys = i_y_start;
                    n_xe = i_x_end;
                    n_ye = i_y_end;
                    n_res_data    = 8'h00;
                    n_res_touched = 1'b0;
                    unique case (t_cmd'(i_cmd))
                        CMD_SET_PX, CMD_CLR_PX, CMD_INV_PX: begin
                            // a pixel is a one-pixel box
                            n_xe    = i_x_start;
                            n_ye    = i_y_start;
                            n_op    = t_op'(i_cmd[1:0]);
                            n_state = S_CLIP;
                        end
                        CMD_FILL_BOX: begin
                            n_op    = OP_SET;
                            n_state = S_CLIP;
                        end
                        CMD_CLR_BOX: begin
                            n_op    = OP_CLR;
                            n_state = S_CLIP;
                        end
                        CMD_INV_BOX: begin
                            n_op    = OP_INV;
                            n_state = S_CLIP;
                        end
                        CMD_CLR_ALL: begin
                            n_cnt     = '0;
                            n_clr_cmd = 1'b1;
                            n_state   = S_CLEAR;
                        end
                        CMD_READ: begin
                            n_state = w_bidx_ok ? S_READ : S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == AW'(BUFSIZE - 1)) begin
                    n_res_touched = 1'b1;
                    n_state       = r_clr_cmd ? S_DONE : S_IDLE;
                end
            end
            S_CLIP: begin
                n_x1 = w_x1[PIX_W-1:0];
                n_x2 = w_x2[PIX_W-1:0];
                n_y1 = w_y1[PIX_W-1:0];
                n_y2 = w_y2[PIX_W-1:0];
                n_state = ((w_x1 <= w_x2) && (w_y1 <= w_y2)) ? S_BASE : S_DONE;
            end
            S_BASE: begin
                n_row_idx = AW'(BUFSIZE - 1) - AW'(r_x1) - w_bank_off;
                n_idx     = AW'(BUFSIZE - 1) - AW'(r_x1) - w_bank_off;
                n_x       = r_x1;
                n_bank    = r_y1[PIX_W-1:3];
                n_state   = S_WALK;
            end
            S_WALK: begin
                // issue the read now, write it back next cycle
                n_wb_valid = 1'b1;
                n_wb_addr  = r_idx;
                n_wb_mask  = w_mask;
                if (r_x == r_x2) begin
                    if (r_bank == r_y2[PIX_W-1:3]) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_bank    = r_bank + 1'b1;
                        n_x       = r_x1;
                        n_row_idx = r_row_idx - AW'(SCREEN_WIDTH);
                        n_idx     = r_row_idx - AW'(SCREEN_WIDTH);
                    end
                end else begin
                    n_x   = r_x + 1'b1;
                    n_idx = r_idx - 1'b1;
                end
            end
            S_FLUSH: begin
                n_res_touched = 1'b1;
                n_state       = S_DONE;
            end
            S_READ: begin
                n_res_data    = i_rd_data;
                n_res_touched = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cnt      <= '0;
            r_clr_cmd  <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_clr_cmd  <= n_clr_cmd;
            r_wb_valid <= n_wb_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_xs          <= n_xs;
        r_ys          <= n_ys;
        r_xe          <= n_xe;
        r_ye          <= n_ye;
        r_x1          <= n_x1;
        r_x2          <= n_x2;
        r_y1          <= n_y1;
        r_y2          <= n_y2;
        r_x           <= n_x;
        r_bank        <= n_bank;
        r_idx         <= n_idx;
        r_row_idx     <= n_row_idx;
        r_wb_addr     <= n_wb_addr;
        r_wb_mask     <= n_wb_mask;
        r_res_data    <= n_res_data;
        r_res_touched <= n_res_touched;
    end

endmodule

[hdl/mono_framebuffer_raster_engine_top.sv]
// Every request, also an empty box, an off-screen pixel or a bad read, ends in a
// single result in the output register.
// Throughput: one request at a time; the box walk handles one framebuffer byte per
// cycle through the single read-modify-write path of the byte memory.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the store
// while requests are stalled.
// ----------------------------------------------------------------------------
// mono_framebuffer_raster_engine_top
// 1 bpp framebuffer with pixel and clipped-box draw, clear-all and byte read.
// ----------------------------------------------------------------------------
module mono_framebuffer_raster_engine_top #(
    parameter int SCREEN_WIDTH  = mfre_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = mfre_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_cmd,
    input  logic signed [8:0] i_x_start,
    input  logic signed [8:0] i_y_start,
    input  logic signed [8:0] i_x_end,
    input  logic signed [8:0] i_y_end,
    input  logic [9:0]        i_byte_index,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_read_data,
    output logic              o_touched
);
    import mfre_pkg::*;

    localparam int BANKS   = (SCREEN_HEIGHT + 7) / 8;
    localparam int BUFSIZE = SCREEN_WIDTH * BANKS;
    localparam int AW      = $clog2(BUFSIZE);

    t_res          w_res;
    logic          w_take;
    logic          w_rd_en, w_wr_en;
    logic [AW-1:0] w_rd_addr, w_wr_addr;
    logic [7:0]    w_rd_data, w_wr_data;

    logic          r_out_valid;
    logic [7:0]    r_read_data;
    logic          r_touched;

    mfre_seq #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .BUFSIZE       (BUFSIZE),
        .AW            (AW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_byte_index (i_byte_index),
        .o_res        (w_res),
        .i_res_take   (w_take),
        .o_rd_en      (w_rd_en),
        .o_rd_addr    (w_rd_addr),
        .i_rd_data    (w_rd_data),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data)
    );

    mfre_store #(
        .DEPTH (BUFSIZE),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // output register: free when empty or drained this cycle
    assign w_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_res.valid) begin
            r_read_data <= w_res.read_data;
            r_touched   <= w_res.touched;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_touched   = r_touched;

endmodule

[hdl/mfre_chk.sv]
// ----------------------------------------------------------------------------
// mfre_chk
// Port-level checker for the raster engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "mono_framebuffer_raster_engine_top_defines.svh"

module mfre_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [2:0]        i_cmd,
    input logic signed [8:0] i_x_start,
    input logic signed [8:0] i_y_start,
    input logic signed [8:0] i_x_end,
    input logic signed [8:0] i_y_end,
    input logic [9:0]        i_byte_index,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [7:0]        o_read_data,
    input logic              o_touched
);
    // a held result keeps its payload
    `MFRE_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_read_data) && $stable(o_touched), "result changed while stalled")

    // only an in-range read returns nonzero data, and it always reports touched
    `MFRE_ASSERT_NOW(a_data_touched, o_out_valid && (o_read_data != 8'h00), o_touched, "nonzero data without touched")

    // every request keeps the engine busy for at least the next cycle
    `MFRE_ASSERT_NXT(a_busy_after_req, i_in_valid && !o_in_stall, o_in_stall, "request taken back to back")

    // the clearing pass after reset holds off requests
    `MFRE_ASSERT_NOW(a_clear_after_rst, $rose(i_rst_n), o_in_stall, "request open during clearing pass")

endmodule

bind mono_framebuffer_raster_engine_top mfre_chk u_chk (.*);

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 1 bpp framebuffer raster engine. A shadow copy
// of the frame bytes is updated for every accepted request and gives the
// result that the engine must return; results are checked in order.
// ----------------------------------------------------------------------------
module tb_top;
    import mfre_pkg::*;

    localparam int SCR_W     = DEF_SCREEN_WIDTH;
    localparam int SCR_H     = DEF_SCREEN_HEIGHT;
    localparam int BANKS     = (SCR_H + 7) / 8;
    localparam int BUF_BYTES = SCR_W * BANKS;
    localparam int MAX_WAIT  = 19;
    localparam int DRAIN_CYC = BUF_BYTES + 80;  // covers the clear-all latency
    localparam int N_RANDOM  = 560;

    typedef struct {
        t_cmd                      cmd;
        logic signed [COORD_W-1:0] xs;
        logic signed [COORD_W-1:0] ys;
        logic signed [COORD_W-1:0] xe;
        logic signed [COORD_W-1:0] ye;
        logic [IDX_W-1:0]          bi;
    } t_draw_req;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              touched;
    } t_draw_res;

    // DUT signals
    logic                      i_clk;
    logic                      i_rst_n;
    logic                      in_valid;
    logic                      o_in_stall;
    t_cmd                      in_cmd;
    logic signed [COORD_W-1:0] in_xs;
    logic signed [COORD_W-1:0] in_ys;
    logic signed [COORD_W-1:0] in_xe;
    logic signed [COORD_W-1:0] in_ye;
    logic [IDX_W-1:0]          in_bi;
    logic                      o_out_valid;
    logic                      out_stall;
    logic [DATA_W-1:0]         o_read_data;
    logic                      o_touched;

    // shadow frame and results still owed by the engine
    logic [7:0] frame_bytes [BUF_BYTES];
    t_draw_res  pending_results[$];

    int  mismatch_count = 0;
    bit  tx_idle_on     = 1'b1;
    bit  rx_idle_on     = 1'b1;
    int  rx_wait        = 0;
    int  hold_left      = 0;
    int  last_byte      = 0;

    mono_framebuffer_raster_engine_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (in_cmd),
        .i_x_start    (in_xs),
        .i_y_start    (in_ys),
        .i_x_end      (in_xe),
        .i_y_end      (in_ye),
        .i_byte_index (in_bi),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_read_data  (o_read_data),
        .o_touched    (o_touched)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // drive defaults so nothing floats before the first request
    initial begin
        in_valid = 1'b0;
        in_cmd   = CMD_READ;
        in_xs    = '0;
        in_ys    = '0;
        in_xe    = '0;
        in_ye    = '0;
        in_bi    = '0;
        foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic t_op op_of(t_cmd cmd);
        case (cmd)
            CMD_SET_PX, CMD_FILL_BOX: return OP_SET;
            CMD_CLR_PX, CMD_CLR_BOX:  return OP_CLR;
            default:                  return OP_INV;
        endcase
    endfunction

    function automatic int byte_of(int x, int y);
        return BUF_BYTES - 1 - x - (y / 8) * SCR_W;
    endfunction

    // update one on-screen pixel of the shadow frame
    function automatic void paint_pixel(int x, int y, t_op op);
        int         idx;
        logic [7:0] mask;
        idx  = byte_of(x, y);
        mask = 8'h80 >> (y % 8);
        case (op)
            OP_SET:  frame_bytes[idx] = frame_bytes[idx] | mask;
            OP_CLR:  frame_bytes[idx] = frame_bytes[idx] & ~mask;
            default: frame_bytes[idx] = frame_bytes[idx] ^ mask;
        endcase
    endfunction

    // apply one request to the shadow frame and return what the engine owes
    function automatic t_draw_res render_request(t_draw_req rq);
        t_draw_res res;
        int        x1, y1, x2, y2;
        res.data    = '0;
        res.touched = 1'b0;
        x1 = int'(rq.xs);
        y1 = int'(rq.ys);
        x2 = int'(rq.xe);
        y2 = int'(rq.ye);
        case (rq.cmd)
            CMD_SET_PX, CMD_CLR_PX, CMD_INV_PX: begin
                if (x1 >= 0 && y1 >= 0 && x1 < SCR_W && y1 < SCR_H) begin
                    paint_pixel(x1, y1, op_of(rq.cmd));
                    res.touched = 1'b1;
                end
            end
            CMD_FILL_BOX, CMD_CLR_BOX, CMD_INV_BOX: begin
                // clip to the screen; an empty box leaves everything alone
                if (x1 < 0) x1 = 0;
                if (y1 < 0) y1 = 0;
                if (x2 > SCR_W - 1) x2 = SCR_W - 1;
                if (y2 > SCR_H - 1) y2 = SCR_H - 1;
                if (x1 <= x2 && y1 <= y2) begin
                    for (int x = x1; x <= x2; x++)
                        for (int y = y1; y <= y2; y++)
                            paint_pixel(x, y, op_of(rq.cmd));
                    res.touched = 1'b1;
                end
            end
            CMD_CLR_ALL: begin
                foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
                res.touched = 1'b1;
            end
            default: begin
                if (rq.bi < BUF_BYTES) begin
                    res.data    = frame_bytes[rq.bi];
                    res.touched = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic send_request(t_draw_req rq);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_cmd   = rq.cmd;
        in_xs    = rq.xs;
        in_ys    = rq.ys;
        in_xe    = rq.xe;
        in_ye    = rq.ye;
        in_bi    = rq.bi;
        in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(render_request(rq));
    endtask

    // fields a command does not use get random values
    function automatic t_draw_req noise_req(t_cmd cmd);
        t_draw_req rq;
        rq.cmd = cmd;
        rq.xs  = COORD_W'($urandom);
        rq.ys  = COORD_W'($urandom);
        rq.xe  = COORD_W'($urandom);
        rq.ye  = COORD_W'($urandom);
        rq.bi  = IDX_W'($urandom);
        return rq;
    endfunction

    task automatic send_pixel(t_cmd cmd, int x, int y);
        t_draw_req rq;
        rq    = noise_req(cmd);
        rq.xs = COORD_W'(x);
        rq.ys = COORD_W'(y);
        if (x >= 0 && y >= 0 && x < SCR_W && y < SCR_H) last_byte = byte_of(x, y);
        send_request(rq);
    endtask

    task automatic send_box(t_cmd cmd, int x1, int y1, int x2, int y2);
        t_draw_req rq;
        rq    = noise_req(cmd);
        rq.xs = COORD_W'(x1);
        rq.ys = COORD_W'(y1);
        rq.xe = COORD_W'(x2);
        rq.ye = COORD_W'(y2);
        if (x1 >= 0 && y1 >= 0 && x1 < SCR_W && y1 < SCR_H)
            last_byte = byte_of(x1, y1);
        send_request(rq);
    endtask

    task automatic send_read(int idx);
        t_draw_req rq;
        rq    = noise_req(CMD_READ);
        rq.bi = IDX_W'(idx);
        send_request(rq);
    endtask

    // ------------------------------------------------------------------
    // result side: stall control and checking
    // ------------------------------------------------------------------
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall = 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                out_stall = 1'b1;
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_draw_res want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] unexpected result: read_data=%02h touched=%0b",
                             $realtime, o_read_data, o_touched);
            end else begin
                want = pending_results.pop_front();
                if (o_read_data !== want.data || o_touched !== want.touched) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"[%0t] result: read_data exp %02h got %02h,",
                                  " touched exp %0b got %0b"},
                                 $realtime, want.data, o_read_data, want.touched,
                                 o_touched);
                end
            end
            rx_wait = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // corner pixels, off-screen pixels and read-back
    task automatic test_pixels();
        send_pixel(CMD_SET_PX, 0, 0);
        send_pixel(CMD_SET_PX, SCR_W - 1, SCR_H - 1);
        send_pixel(CMD_INV_PX, SCR_W - 1, 0);
        send_pixel(CMD_SET_PX, -1, 0);
        send_pixel(CMD_SET_PX, SCR_W, 5);
        send_pixel(CMD_CLR_PX, 5, SCR_H);
        send_pixel(CMD_INV_PX, -256, -256);
        send_pixel(CMD_SET_PX, 255, 255);
        send_read(BUF_BYTES - 1);
        send_read(0);
        send_read(byte_of(SCR_W - 1, 0));
        send_pixel(CMD_CLR_PX, 0, 0);
        send_read(BUF_BYTES - 1);
    endtask

    // full-screen, clipped and empty boxes, then clear-all
    task automatic test_boxes();
        send_box(CMD_FILL_BOX, -256, -256, 255, 255);
        send_read(500);
        send_box(CMD_INV_BOX, -5, -5, 3, 3);
        send_box(CMD_CLR_BOX, 10, 0, 9, SCR_H - 1);
        send_box(CMD_FILL_BOX, -256, 0, -1, SCR_H - 1);
        send_read(BUF_BYTES - 1);
        send_request(noise_req(CMD_CLR_ALL));
        send_read(0);
    endtask

    // result side blocked for a long stretch while requests keep coming
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        hold_left  = 400;
        send_pixel(CMD_SET_PX, 3, 9);
        send_read(byte_of(3, 9));
        send_box(CMD_FILL_BOX, 20, 20, 23, 27);
        send_read(byte_of(21, 24));
        tx_idle_on = 1'b1;
    endtask

    // mostly coherent draw and read-back traffic, with noise
    task automatic test_random_traffic();
        int   pick, x1, y1;
        t_cmd cmd;
        for (int n = 0; n < N_RANDOM; n++) begin
            // change the idling mix every 40 requests
            if (n % 40 == 0) begin
                tx_idle_on = $urandom_range(0, 2) != 0;
                rx_idle_on = $urandom_range(0, 2) != 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                cmd = t_cmd'($urandom_range(CMD_SET_PX, CMD_INV_PX));
                if ($urandom_range(0, 99) < 85)
                    send_pixel(cmd, $urandom_range(0, SCR_W - 1),
                               $urandom_range(0, SCR_H - 1));
                else
                    send_pixel(cmd, $signed($urandom_range(0, 511)) - 256,
                               $signed($urandom_range(0, 511)) - 256);
            end else if (pick < 50) begin
                cmd  = t_cmd'($urandom_range(CMD_FILL_BOX, CMD_INV_BOX));
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    x1 = $signed($urandom_range(0, SCR_W + 7)) - 4;
                    y1 = $signed($urandom_range(0, SCR_H + 7)) - 4;
                    send_box(cmd, x1, y1, x1 + $urandom_range(0, 15),
                             y1 + $urandom_range(0, 15));
                end else if (pick < 95) begin
                    send_box(cmd, $signed($urandom_range(0, 511)) - 256,
                             $signed($urandom_range(0, 511)) - 256,
                             $signed($urandom_range(0, 511)) - 256,
                             $signed($urandom_range(0, 511)) - 256);
                end else begin
                    send_box(cmd, -$signed($urandom_range(0, 256)),
                             -$signed($urandom_range(0, 256)),
                             $urandom_range(SCR_W - 1, 255),
                             $urandom_range(SCR_H - 1, 255));
                end
            end else if (pick < 97) begin
                if ($urandom_range(0, 1))
                    send_read(last_byte);
                else
                    send_read($urandom_range(0, 1023));
            end else begin
                send_request(noise_req(CMD_CLR_ALL));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_pixels();
        test_boxes();
        test_backpressure();
        test_random_traffic();

        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("mono_framebuffer_raster_engine_top: match");
        else
            $display("mono_framebuffer_raster_engine_top: mismatch");
        $finish;
    end

    // watchdog
    initial begin
        #40ms;
        $display("mono_framebuffer_raster_engine_top: mismatch");
        $finish;
    end

endmodule
